// ===== design/lav_pkg.sv =====
// Shared widths, word layouts and vector types of the look-at view matrix pipeline.
// No dependencies; every other file of the block imports this package.
package lav_pkg;

    localparam int COORD_W   = 32;              // eye, target and up coordinates
    localparam int FRAC_W    = 16;              // fraction bits of Q16.16
    localparam int UNIT_W    = FRAC_W + 2;      // unit axis components
    localparam int ONE_Q     = 1 << FRAC_W;
    localparam int DIR_W     = COORD_W + 1;     // target minus eye
    localparam int ALIGN_W   = 24;              // magnitude bits after alignment
    localparam int AVEC_W    = ALIGN_W + 1;     // signed aligned component
    localparam int SQP_W     = 2 * ALIGN_W;     // one square
    localparam int SUM_W     = SQP_W + 2;       // sum of three squares
    localparam int SQR_SHIFT = 12;
    localparam int SQ_W      = SUM_W + SQR_SHIFT;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int NUM_SHIFT = FRAC_W + 6;
    localparam int QUO_W     = 18;
    localparam int DIV_W     = ROOT_W + QUO_W;
    localparam int CROSS_W   = 44;              // forward x aligned up
    localparam int TUP_W     = 37;              // right x forward
    localparam int TRN_W     = 53;              // translation sums
    localparam int IN_W      = 9 * COORD_W;
    localparam int OUT_W     = 264;             // 9 * 18 + 3 * 32, padded to bytes

    typedef logic [2:0][COORD_W-1:0] cvec_t;
    typedef logic [2:0][DIR_W-1:0]   dvec_t;
    typedef logic [2:0][UNIT_W-1:0]  uvec_t;
    typedef logic [2:0][AVEC_W-1:0]  avec_t;
    typedef logic [2:0][ALIGN_W-1:0] mvec_t;
    typedef logic [2:0][DIV_W-1:0]   nvec_t;
    typedef logic [2:0][QUO_W-1:0]   qvec_t;

endpackage

// ===== design/look_at_view_matrix.sv =====
// Top level of the look-at view matrix pipeline: stream ports, cross products, translation.
// Depends on lav_pkg, lav_norm and lav_align.
//
//  channel | signals                    | one word
//  --------+----------------------------+-------------------------------------------
//  input   | s_tvalid s_tready s_tdata  | eye, target and up hint, 288 bits
//  output  | m_tvalid m_tready m_tdata  | right, true up, back, translation, 264 bits
//
// One word is accepted per cycle while s_tready is high; each result passes through
// the two normalizers, each with a 31-stage square root and an 18-stage divider.
// The whole pipeline advances together whenever the output register is empty or taken,
// so s_tready is low only while a result waits on m_tready; nothing is dropped or repeated.
// rst_n clears every valid bit asynchronously; data registers are not reset.
module look_at_view_matrix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [lav_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // right_x, right_y, right_z, true_up_x, true_up_y, true_up_z, back_x, back_y,
    // back_z, shift_x, shift_y, shift_z, six zero bits
    output logic [lav_pkg::OUT_W-1:0]   m_tdata
);
    import lav_pkg::*;

    localparam int S1W = 2 * 3 * COORD_W;
    localparam int S2W = 3 * COORD_W + 3 * UNIT_W;
    localparam logic signed [TRN_W-1:0] HALF    = TRN_W'(ONE_Q / 2);
    localparam logic signed [TRN_W-1:0] SAT_MAX = (TRN_W'(1) <<< (COORD_W - 1)) - 1;
    localparam logic signed [TRN_W-1:0] SAT_MIN = -(TRN_W'(1) <<< (COORD_W - 1));

    logic en;
    logic vout_reg;

    assign en       = !vout_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = vout_reg;

    // Input register and direction.
    logic  v0_reg, v1_reg;
    cvec_t eye0_reg, tgt0_reg, up0_reg, eye1_reg, up1_reg;
    dvec_t dir1_reg, dir1_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir1_next[i] = DIR_W'($signed(tgt0_reg[i])) - DIR_W'($signed(eye0_reg[i]));
        end
    end

    logic           vn1;
    uvec_t          fwd_n1;
    logic [S1W-1:0] side_n1;
    cvec_t          eye_n1, up_n1;

    lav_norm #(.IW(DIR_W), .PW(S1W)) u_norm_fwd
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .vec       (dir1_reg),
        .in_side   ({eye1_reg, up1_reg}),
        .out_valid (vn1),
        .unit      (fwd_n1),
        .out_side  (side_n1)
    );

    assign {eye_n1, up_n1} = side_n1;

    logic           va2;
    avec_t          ups;
    logic [S2W-1:0] side_a2;
    cvec_t          eye_a2;
    uvec_t          fwd_a2;

    lav_align #(.IW(COORD_W), .PW(S2W)) u_align_up
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vn1),
        .vec       (up_n1),
        .in_side   ({eye_n1, fwd_n1}),
        .out_valid (va2),
        .avec      (ups),
        .nz        (),
        .out_side  (side_a2)
    );

    assign {eye_a2, fwd_a2} = side_a2;

    // Forward crossed with the aligned up hint.
    logic                        vc1_reg, vc2_reg;
    logic [2:0][CROSS_W-1:0]     pa_reg, pb_reg, pa_next, pb_next, cr_reg;
    cvec_t                       eyec1_reg, eyec2_reg;
    uvec_t                       fwdc1_reg, fwdc2_reg;

    always_comb
    begin
        logic signed [CROSS_W-1:0] f [3];
        logic signed [CROSS_W-1:0] u [3];
        for (int i = 0; i < 3; i++)
        begin
            f[i] = CROSS_W'($signed(fwd_a2[i]));
            u[i] = CROSS_W'($signed(ups[i]));
        end
        pa_next[0] = f[1] * u[2];
        pb_next[0] = f[2] * u[1];
        pa_next[1] = f[2] * u[0];
        pb_next[1] = f[0] * u[2];
        pa_next[2] = f[0] * u[1];
        pb_next[2] = f[1] * u[0];
    end

    logic           vn2;
    uvec_t          rgt_n2;
    logic [S2W-1:0] side_n2;
    cvec_t          eye_n2;
    uvec_t          fwd_n2;

    lav_norm #(.IW(CROSS_W), .PW(S2W)) u_norm_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc2_reg),
        .vec       (cr_reg),
        .in_side   ({eyec2_reg, fwdc2_reg}),
        .out_valid (vn2),
        .unit      (rgt_n2),
        .out_side  (side_n2)
    );

    assign {eye_n2, fwd_n2} = side_n2;

    // True up = right x forward, rounded back to Q16.16.
    logic                    vt1_reg, vt2_reg, vt3_reg;
    logic [2:0][TUP_W-1:0]   qa_reg, qb_reg, qa_next, qb_next, tp_reg;
    cvec_t                   eyet1_reg, eyet2_reg, eyet3_reg;
    uvec_t                   fwdt1_reg, fwdt2_reg;
    uvec_t                   rgtt1_reg, rgtt2_reg, rgtt3_reg;
    uvec_t                   tupt3_reg, tupt3_next, bckt3_reg, bckt3_next;

    always_comb
    begin
        logic signed [TUP_W-1:0] r [3];
        logic signed [TUP_W-1:0] f [3];
        for (int i = 0; i < 3; i++)
        begin
            r[i] = TUP_W'($signed(rgt_n2[i]));
            f[i] = TUP_W'($signed(fwd_n2[i]));
        end
        qa_next[0] = r[1] * f[2];
        qb_next[0] = r[2] * f[1];
        qa_next[1] = r[2] * f[0];
        qb_next[1] = r[0] * f[2];
        qa_next[2] = r[0] * f[1];
        qb_next[2] = r[1] * f[0];
    end

    always_comb
    begin
        logic [TUP_W-1:0]  m;
        logic [TUP_W-1:0]  n;
        logic [UNIT_W-1:0] u;
        for (int i = 0; i < 3; i++)
        begin
            m = tp_reg[i][TUP_W-1] ? (~tp_reg[i] + 1'b1) : tp_reg[i];
            n = (m + TUP_W'(ONE_Q / 2)) >> FRAC_W;
            if (n > TUP_W'(ONE_Q))
            begin
                n = TUP_W'(ONE_Q);
            end
            u = n[UNIT_W-1:0];
            tupt3_next[i] = tp_reg[i][TUP_W-1] ? (~u + 1'b1) : u;
            bckt3_next[i] = ~fwdt2_reg[i] + 1'b1;
        end
    end

    // Translation: minus each axis dotted with eye, rounded half up, saturated.
    logic                            vx1_reg, vx2_reg;
    logic [2:0][2:0][TRN_W-1:0]      pr_reg, pr_next;
    logic [2:0][TRN_W-1:0]           tr_reg, tr_next;
    uvec_t                           rgtx1_reg, rgtx2_reg, tupx1_reg, tupx2_reg;
    uvec_t                           bckx1_reg, bckx2_reg;
    uvec_t                           rgto_reg, tupo_reg, bcko_reg;
    cvec_t                           shfo_reg, shfo_next;

    always_comb
    begin
        logic signed [TRN_W-1:0] e [3];
        logic signed [TRN_W-1:0] s;
        uvec_t                   ax [3];
        ax[0] = rgtt3_reg;
        ax[1] = tupt3_reg;
        ax[2] = bckt3_reg;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = TRN_W'($signed(eyet3_reg[i]));
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_next[j][i] = TRN_W'($signed(ax[j][i])) * e[i];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            s = $signed(pr_reg[j][0]) + $signed(pr_reg[j][1]) + $signed(pr_reg[j][2]);
            tr_next[j] = (HALF - s) >>> FRAC_W;
        end
        for (int j = 0; j < 3; j++)
        begin
            if ($signed(tr_reg[j]) > SAT_MAX)
            begin
                shfo_next[j] = SAT_MAX[COORD_W-1:0];
            end
            else if ($signed(tr_reg[j]) < SAT_MIN)
            begin
                shfo_next[j] = SAT_MIN[COORD_W-1:0];
            end
            else
            begin
                shfo_next[j] = tr_reg[j][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            vc1_reg  <= 1'b0;
            vc2_reg  <= 1'b0;
            vt1_reg  <= 1'b0;
            vt2_reg  <= 1'b0;
            vt3_reg  <= 1'b0;
            vx1_reg  <= 1'b0;
            vx2_reg  <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= s_tvalid;
            v1_reg   <= v0_reg;
            vc1_reg  <= va2;
            vc2_reg  <= vc1_reg;
            vt1_reg  <= vn2;
            vt2_reg  <= vt1_reg;
            vt3_reg  <= vt2_reg;
            vx1_reg  <= vt3_reg;
            vx2_reg  <= vx1_reg;
            vout_reg <= vx2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eye0_reg  <= s_tdata[3*COORD_W-1:0];
            tgt0_reg  <= s_tdata[6*COORD_W-1:3*COORD_W];
            up0_reg   <= s_tdata[9*COORD_W-1:6*COORD_W];
            dir1_reg  <= dir1_next;
            eye1_reg  <= eye0_reg;
            up1_reg   <= up0_reg;

            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            eyec1_reg <= eye_a2;
            fwdc1_reg <= fwd_a2;
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= pa_reg[i] - pb_reg[i];
                tp_reg[i] <= qa_reg[i] - qb_reg[i];
            end
            eyec2_reg <= eyec1_reg;
            fwdc2_reg <= fwdc1_reg;

            qa_reg    <= qa_next;
            qb_reg    <= qb_next;
            eyet1_reg <= eye_n2;
            fwdt1_reg <= fwd_n2;
            rgtt1_reg <= rgt_n2;
            eyet2_reg <= eyet1_reg;
            fwdt2_reg <= fwdt1_reg;
            rgtt2_reg <= rgtt1_reg;
            eyet3_reg <= eyet2_reg;
            rgtt3_reg <= rgtt2_reg;
            tupt3_reg <= tupt3_next;
            bckt3_reg <= bckt3_next;

            pr_reg    <= pr_next;
            rgtx1_reg <= rgtt3_reg;
            tupx1_reg <= tupt3_reg;
            bckx1_reg <= bckt3_reg;
            tr_reg    <= tr_next;
            rgtx2_reg <= rgtx1_reg;
            tupx2_reg <= tupx1_reg;
            bckx2_reg <= bckx1_reg;
            shfo_reg  <= shfo_next;
            rgto_reg  <= rgtx2_reg;
            tupo_reg  <= tupx2_reg;
            bcko_reg  <= bckx2_reg;
        end
    end

    assign m_tdata = {6'b0, shfo_reg, bcko_reg, tupo_reg, rgto_reg};

endmodule

// ===== design/lav_align.sv =====
// Three-stage alignment: scales a vector so that its largest magnitude has 24 bits.
// Depends on lav_pkg; used by lav_norm and by the top level for the up hint.
module lav_align
#(
    parameter int IW = 33,
    parameter int PW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][IW-1:0] vec,
    input  logic [PW-1:0]    in_side,
    output logic             out_valid,
    output lav_pkg::avec_t   avec,
    output logic             nz,
    output logic [PW-1:0]    out_side
);
    import lav_pkg::*;

    localparam int LW = $clog2(IW + 1);

    function automatic logic [LW-1:0] bit_len(input logic [IW-1:0] m);
        logic [LW-1:0] l;
        l = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (m[i])
            begin
                l = LW'(i + 1);
            end
        end
        return l;
    endfunction

    logic [2:0]          v_reg;
    logic [2:0][IW-1:0]  mag1_reg, mag1_next, mag2_reg;
    logic [2:0]          sgn1_reg, sgn2_reg;
    logic [PW-1:0]       side1_reg, side2_reg, side3_reg;
    logic [LW-1:0]       len2_reg, len2_next;
    avec_t               a3_reg, a3_next;
    logic                nz3_reg;
    logic [IW-1:0]       mx;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        mx = mag1_reg[0];
        if (mag1_reg[1] > mx)
        begin
            mx = mag1_reg[1];
        end
        if (mag1_reg[2] > mx)
        begin
            mx = mag1_reg[2];
        end
        len2_next = bit_len(mx);
    end

    // Shifting the magnitude with 24 zero bits appended right by its length
    // covers both the left and the truncating right alignment.
    always_comb
    begin
        logic [IW+ALIGN_W-1:0] wide;
        logic [AVEC_W-1:0]     ae;
        for (int i = 0; i < 3; i++)
        begin
            wide = {mag2_reg[i], {ALIGN_W{1'b0}}} >> len2_reg;
            ae = {1'b0, wide[ALIGN_W-1:0]};
            a3_next[i] = sgn2_reg[i] ? (~ae + 1'b1) : ae;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            for (int i = 0; i < 3; i++)
            begin
                sgn1_reg[i] <= vec[i][IW-1];
            end
            side1_reg <= in_side;
            mag2_reg  <= mag1_reg;
            sgn2_reg  <= sgn1_reg;
            len2_reg  <= len2_next;
            side2_reg <= side1_reg;
            a3_reg    <= a3_next;
            nz3_reg   <= (len2_reg != '0);
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign avec      = a3_reg;
    assign nz        = nz3_reg;
    assign out_side  = side3_reg;

endmodule

// ===== design/lav_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side word in tow.
// Depends on lav_pkg; used by lav_norm.
module lav_sqrt
#(
    parameter int PW = 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [lav_pkg::SQ_W-1:0]     radicand,
    input  logic [PW-1:0]                in_side,
    output logic                         out_valid,
    output logic [lav_pkg::ROOT_W-1:0]   root,
    output logic [PW-1:0]                out_side
);
    import lav_pkg::*;

    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [SQ_W-1:0]   res_reg  [ROOT_W];
    logic [PW-1:0]     side_reg [ROOT_W];
    logic [ROOT_W-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [SQ_W-1:0] rem_in, res_in, trial, rem_next, res_next;
        logic [PW-1:0]   side_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = radicand;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== design/lav_div.sv =====
// Pipelined restoring divider, three numerators over one divisor, one quotient bit a stage.
// Depends on lav_pkg; used by lav_norm.
module lav_div
#(
    parameter int PW = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  lav_pkg::nvec_t              num,
    input  logic [lav_pkg::ROOT_W-1:0]  den,
    input  logic [PW-1:0]               in_side,
    output logic                        out_valid,
    output lav_pkg::qvec_t              quo,
    output logic [PW-1:0]               out_side
);
    import lav_pkg::*;

    nvec_t             rem_reg  [QUO_W];
    qvec_t             quo_reg  [QUO_W];
    logic [ROOT_W-1:0] den_reg  [QUO_W];
    logic [PW-1:0]     side_reg [QUO_W];
    logic [QUO_W-1:0]  v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QUO_W-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - j;
        nvec_t             rem_in, rem_next;
        qvec_t             quo_in, quo_next;
        logic [ROOT_W-1:0] den_in;
        logic [PW-1:0]     side_in;
        logic [DIV_W-1:0]  dsh;

        if (j == 0)
        begin : g_first
            assign rem_in  = num;
            assign quo_in  = '0;
            assign den_in  = den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            dsh = DIV_W'(den_in) << SH;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = rem_in[i];
                quo_next[i] = quo_in[i];
                if (rem_in[i] >= dsh)
                begin
                    rem_next[i]     = rem_in[i] - dsh;
                    quo_next[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== design/lav_norm.sv =====
// Vector normalizer: align, sum of squares, square root, divide and clamp, 56 stages.
// Depends on lav_pkg, lav_align, lav_sqrt and lav_div.
module lav_norm
#(
    parameter int IW = 33,
    parameter int PW = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0][IW-1:0] vec,
    input  logic [PW-1:0]      in_side,
    output logic               out_valid,
    output lav_pkg::uvec_t     unit,
    output logic [PW-1:0]      out_side
);
    import lav_pkg::*;

    localparam int SW = PW + 4 + 3 * ALIGN_W;
    localparam int DW = PW + 4;

    logic          va;
    avec_t         a;
    logic          anz;
    logic [PW-1:0] aside;

    lav_align #(.IW(IW), .PW(PW)) u_align
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .vec       (vec),
        .in_side   (in_side),
        .out_valid (va),
        .avec      (a),
        .nz        (anz),
        .out_side  (aside)
    );

    // Squares, then their sum.
    logic                       vq_reg, vs_reg, vn_reg, vf_reg;
    mvec_t                      magq_reg, magq_next, mags_reg;
    logic [2:0]                 sgnq_reg, sgns_reg;
    logic                       nzq_reg, nzs_reg;
    logic [PW-1:0]              sideq_reg, sides_reg;
    logic [2:0][SQP_W-1:0]      sq_reg, sq_next;
    logic [SUM_W-1:0]           sum_reg;

    always_comb
    begin
        logic [AVEC_W-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m = a[i][AVEC_W-1] ? (~a[i] + 1'b1) : a[i];
            magq_next[i] = m[ALIGN_W-1:0];
            sq_next[i] = SQP_W'(magq_next[i]) * SQP_W'(magq_next[i]);
        end
    end

    logic              vr;
    logic [ROOT_W-1:0] root;
    logic [SW-1:0]     rside;
    logic [PW-1:0]     side_r;
    logic              nz_r;
    logic [2:0]        sgn_r;
    mvec_t             mag_r;

    lav_sqrt #(.PW(SW)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_reg),
        .radicand  ({sum_reg, {SQR_SHIFT{1'b0}}}),
        .in_side   ({sides_reg, nzs_reg, sgns_reg, mags_reg}),
        .out_valid (vr),
        .root      (root),
        .out_side  (rside)
    );

    assign {side_r, nz_r, sgn_r, mag_r} = rside;

    // Numerators carry half the divisor so the quotient rounds to nearest.
    nvec_t             num_reg, num_next;
    logic [ROOT_W-1:0] den_reg;
    logic [DW-1:0]     sidev_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (DIV_W'(mag_r[i]) << NUM_SHIFT) + DIV_W'(root >> 1);
        end
    end

    logic          vd;
    qvec_t         quo;
    logic [DW-1:0] dside;
    logic [PW-1:0] side_d;
    logic          nz_d;
    logic [2:0]    sgn_d;

    lav_div #(.PW(DW)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vn_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_side   (sidev_reg),
        .out_valid (vd),
        .quo       (quo),
        .out_side  (dside)
    );

    assign {side_d, nz_d, sgn_d} = dside;

    uvec_t         unit_reg, unit_next;
    logic [PW-1:0] sidef_reg;

    always_comb
    begin
        logic [QUO_W-1:0]  n;
        logic [UNIT_W-1:0] u;
        for (int i = 0; i < 3; i++)
        begin
            n = quo[i];
            if (n > QUO_W'(ONE_Q))
            begin
                n = QUO_W'(ONE_Q);
            end
            u = UNIT_W'(n);
            unit_next[i] = !nz_d ? '0 : (sgn_d[i] ? (~u + 1'b1) : u);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vs_reg <= 1'b0;
            vn_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg <= va;
            vs_reg <= vq_reg;
            vn_reg <= vr;
            vf_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magq_reg  <= magq_next;
            for (int i = 0; i < 3; i++)
            begin
                sgnq_reg[i] <= a[i][AVEC_W-1];
            end
            nzq_reg   <= anz;
            sideq_reg <= aside;
            sq_reg    <= sq_next;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            mags_reg  <= magq_reg;
            sgns_reg  <= sgnq_reg;
            nzs_reg   <= nzq_reg;
            sides_reg <= sideq_reg;
            num_reg   <= num_next;
            den_reg   <= root;
            sidev_reg <= {side_r, nz_r, sgn_r};
            unit_reg  <= unit_next;
            sidef_reg <= side_d;
        end
    end

    assign out_valid = vf_reg;
    assign unit      = unit_reg;
    assign out_side  = sidef_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the look-at view matrix pipeline.
// It needs lav_pkg and look_at_view_matrix; each result is checked against a bit-exact predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lav_pkg::*;

    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 300;
    localparam longint ONE = 64'sd65536;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // right_x..z, true_up_x..z, back_x..z, shift_x..z, six zero bits
    logic [OUT_W-1:0]    m_tdata;

    logic [OUT_W-1:0]    pending_views[$];
    int                  errors = 0;
    int                  words_sent = 0;
    int                  words_checked = 0;
    bit                  no_idle = 0;
    int                  quiet_cycles = 0;

    string field_names[12] = '{"right_x", "right_y", "right_z", "true_up_x", "true_up_y",
        "true_up_z", "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};

    look_at_view_matrix dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic bit [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale so that the largest magnitude has exactly 24 significant bits.
    function automatic bit align_axis(input longint v[3], output longint a[3]);
        bit [63:0] mx;
        bit [63:0] m;
        int        len;
        mx = 0;
        len = 0;
        for (int i = 0; i < 3; i++)
            if (magnitude(v[i]) > mx)
                mx = magnitude(v[i]);
        for (int i = 0; i < 3; i++)
            a[i] = 0;
        if (mx == 0)
            return 0;
        while (len < 64 && (mx >> len) != 0)
            len++;
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(v[i]);
            m = (len > ALIGN_W) ? (m >> (len - ALIGN_W)) : (m << (ALIGN_W - len));
            a[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
        end
        return 1;
    endfunction

    function automatic void unit_axis(input longint v[3], output longint u[3]);
        longint    a[3];
        bit [63:0] s;
        bit [63:0] q;
        bit [63:0] n;
        s = 0;
        for (int i = 0; i < 3; i++)
            u[i] = 0;
        if (!align_axis(v, a))
            return;
        for (int i = 0; i < 3; i++)
            s += magnitude(a[i]) * magnitude(a[i]);
        q = int_sqrt(s << SQR_SHIFT);
        for (int i = 0; i < 3; i++)
        begin
            n = ((magnitude(a[i]) << NUM_SHIFT) + q / 2) / q;
            if (n > ONE)
                n = ONE;
            u[i] = (a[i] < 0) ? -longint'(n) : longint'(n);
        end
    endfunction

    function automatic void cross3(input longint p[3], input longint r[3], output longint c[3]);
        c[0] = p[1] * r[2] - p[2] * r[1];
        c[1] = p[2] * r[0] - p[0] * r[2];
        c[2] = p[0] * r[1] - p[1] * r[0];
    endfunction

    function automatic longint floor_frac(input longint x);
        if (x >= 0)
            return x >>> FRAC_W;
        return -longint'((magnitude(x) + ONE - 1) >> FRAC_W);
    endfunction

    // Minus the dot product with eye, split so the products stay exact.
    function automatic logic [31:0] shift_of(input longint axis[3], input longint eye[3]);
        longint hi;
        longint lo;
        longint r;
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++)
        begin
            hi += axis[i] * (eye[i] >>> FRAC_W);
            lo += axis[i] * (eye[i] & (ONE - 1));
        end
        r = -hi + floor_frac(-lo + ONE / 2);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic logic [OUT_W-1:0] view_matrix(input logic [IN_W-1:0] word);
        longint eye[3], dir[3], upv[3], ups[3];
        longint fwd[3], rgt[3], tup[3], back[3], tmp[3];
        bit [63:0] n;
        logic [OUT_W-1:0] v;
        v = '0;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'(signed'(word[i*32 +: 32]));
            dir[i] = longint'(signed'(word[(3+i)*32 +: 32])) - eye[i];
            upv[i] = longint'(signed'(word[(6+i)*32 +: 32]));
        end
        unit_axis(dir, fwd);
        void'(align_axis(upv, ups));
        cross3(fwd, ups, tmp);
        unit_axis(tmp, rgt);
        cross3(rgt, fwd, tmp);
        for (int i = 0; i < 3; i++)
        begin
            n = (magnitude(tmp[i]) + ONE / 2) >> FRAC_W;
            if (n > ONE)
                n = ONE;
            tup[i] = (tmp[i] < 0) ? -longint'(n) : longint'(n);
            back[i] = -fwd[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            v[i*UNIT_W +: UNIT_W] = rgt[i][UNIT_W-1:0];
            v[(3+i)*UNIT_W +: UNIT_W] = tup[i][UNIT_W-1:0];
            v[(6+i)*UNIT_W +: UNIT_W] = back[i][UNIT_W-1:0];
        end
        v[9*UNIT_W +: 32] = shift_of(rgt, eye);
        v[9*UNIT_W+32 +: 32] = shift_of(tup, eye);
        v[9*UNIT_W+64 +: 32] = shift_of(back, eye);
        return v;
    endfunction

    // Sends one camera word; entered and left at a falling edge.
    task automatic send_camera(input logic [31:0] e[3], input logic [31:0] t[3],
                               input logic [31:0] u[3]);
        int gap;
        logic [IN_W-1:0] word;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        for (int i = 0; i < 3; i++)
        begin
            word[i*32 +: 32] = e[i];
            word[(3+i)*32 +: 32] = t[i];
            word[(6+i)*32 +: 32] = u[i];
        end
        if (gap > 0)
        begin
            s_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = word;
        s_tvalid = 1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_views.push_back(view_matrix(word));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 0;
        while (pending_views.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] e[3], t[3], u[3];
        // Eye on the target: everything is zero.
        e = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000};
        send_camera(e, e, '{32'h0, 32'h0001_0000, 32'h0});
        send_camera('{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0});
        // Ordinary camera looking down minus z.
        send_camera('{32'h0, 32'h0, 32'h0005_0000}, '{32'h0, 32'h0, 32'h0},
                    '{32'h0, 32'h0001_0000, 32'h0});
        // Zero up hint and up hint parallel to forward.
        send_camera('{32'h0003_0000, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0},
                    '{32'h0, 32'h0, 32'h0});
        send_camera('{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0004_0000, 32'h0},
                    '{32'h0, 32'hFFFE_0000, 32'h0});
        // Coordinate extremes and saturating translation.
        e = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        u = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        send_camera(e, t, u);
        send_camera(t, e, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
        send_camera(e, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE},
                    '{32'h0, 32'h0001_0000, 32'h0});
        send_camera(t, '{32'h8000_0001, 32'h8000_0000, 32'h8000_0000},
                    '{32'h0, 32'h0, 32'h0001_0000});
        send_camera('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                    '{32'h7FFF_0000, 32'h8000_1000, 32'h7FFF_0100},
                    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001});
        // Tiny direction and tiny up hint.
        send_camera('{32'h1, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0},
                    '{32'h0, 32'h1, 32'h0});
        send_camera('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    '{32'h0, 32'h0, 32'h0}, '{32'h1, 32'hFFFF_FFFF, 32'h1});
        wait_drained();
    endtask

    function automatic logic [31:0] random_coord(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task automatic test_random(input int count);
        logic [31:0] e[3], t[3], u[3];
        int kind;
        int shape;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 2);
            shape = $urandom_range(0, 19);
            for (int i = 0; i < 3; i++)
            begin
                e[i] = random_coord(kind);
                t[i] = random_coord(kind);
                u[i] = random_coord($urandom_range(0, 2));
            end
            if (shape == 0)
                t = e;
            else if (shape == 1)
                u = '{32'h0, 32'h0, 32'h0};
            else if (shape == 2)
                for (int i = 0; i < 3; i++)
                    u[i] = (t[i] - e[i]) <<< $urandom_range(0, 2);
            else if (shape == 3)
                for (int i = 0; i < 3; i++)
                    t[i] = e[i] + $urandom_range(0, 15) - 8;
            send_camera(e, t, u);
        end
    endtask

    task automatic test_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    // Result side: random stall per word, compare with the oldest prediction.
    initial
    begin
        int gap;
        logic [OUT_W-1:0] want;
        m_tready = 0;
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_tready = 0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1;
            do
                @(posedge clk);
            while (!(m_tvalid && rst_n));
            if (pending_views.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_views.pop_front();
                words_checked++;
                for (int i = 0; i < 12; i++)
                begin
                    if (i < 9 && want[i*UNIT_W +: UNIT_W] !== m_tdata[i*UNIT_W +: UNIT_W])
                    begin
                        $display("%0t: %s expected %0d actual %0d", $realtime, field_names[i],
                            $signed(want[i*UNIT_W +: UNIT_W]),
                            $signed(m_tdata[i*UNIT_W +: UNIT_W]));
                        errors++;
                    end
                    if (i >= 9 && want[9*UNIT_W+(i-9)*32 +: 32]
                        !== m_tdata[9*UNIT_W+(i-9)*32 +: 32])
                    begin
                        $display("%0t: %s expected %0d actual %0d", $realtime, field_names[i],
                            $signed(want[9*UNIT_W+(i-9)*32 +: 32]),
                            $signed(m_tdata[9*UNIT_W+(i-9)*32 +: 32]));
                        errors++;
                    end
                end
                if (m_tdata[OUT_W-1:9*UNIT_W+96] !== '0)
                begin
                    $display("%0t: padding expected 0 actual %h", $realtime,
                        m_tdata[OUT_W-1:9*UNIT_W+96]);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_random(300);
        test_pause();
        no_idle = 1;
        test_random(120);
        no_idle = 0;
        test_random(200);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d camera words and checked %0d view matrices,", words_sent,
            words_checked);
        $display("covering coincident eye and target, degenerate up hints and saturation.");
        if (errors == 0 && pending_views.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
design/lav_pkg.sv
design/lav_align.sv
design/lav_sqrt.sv
design/lav_div.sv
design/lav_norm.sv
design/look_at_view_matrix.sv
test/tb_top.sv
